// ----- rtl/core/fifo_page_replacement_dirty_defines.svh -----
// Assertion macros shared by the FIFO page replacement RTL.
`ifndef FIFO_PAGE_REPLACEMENT_DIRTY_DEFINES_SVH
`define FIFO_PAGE_REPLACEMENT_DIRTY_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FPRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fprd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FPRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fprd assertion failed");

`endif

// ----- rtl/core/fprd_pkg.sv -----
// Package with types and constants of the FIFO page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package fprd_pkg;

	localparam int MAX_FRAMES = 128;
	localparam int PAGE_BITS  = 20;
	localparam int CFG_W      = 8;
	localparam int CNT_W      = 32;
	localparam int OCC_W      = $clog2(MAX_FRAMES + 1);

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [OCC_W-1:0]     occ_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CFG_W-1:0]     cfg_t;

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic active;
		logic shift;
		logic load;
		logic mark_en;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/fprd_cell.sv -----
// One frame cell: holds a page and its dirty bit, compares and shifts toward the head.
`timescale 1ns / 1ps
`default_nettype none
module fprd_cell (
	input  wire                    clk,
	input  fprd_pkg::cell_ctrl_t   ctrl,
	input  fprd_pkg::page_t        key_page,
	input  wire                    key_dirty,
	input  fprd_pkg::page_t        next_page,
	input  wire                    next_dirty,
	output fprd_pkg::page_t        page,
	output logic                   dirty,
	output logic                   match
);
	import fprd_pkg::*;

	page_t page_q;
	logic  dirty_q;

	assign match = ctrl.active && (page_q == key_page);
	assign page  = page_q;
	assign dirty = dirty_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			page_q  <= key_page;
			dirty_q <= key_dirty;
		end else if (ctrl.shift) begin
			page_q  <= next_page;
			dirty_q <= next_dirty;
		end else if (ctrl.mark_en && match) begin
			dirty_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/fifo_page_replacement_dirty.sv -----
// Top level of the FIFO page replacement engine with dirty tracking.
//
// Requests enter on in_valid/in_stall with opcode, page_number and dirty.
// A request is taken at a clock edge where in_valid is high and in_stall low.
// Every request yields exactly one result on out_valid/out_stall, in the
// cycle after it is taken, from an output register.
// All resident frames are compared in parallel in a row of frame cells, so
// one request is taken per cycle unless in_stall is high; the row shifts by
// one cell on an eviction. While the result register is full and out_stall
// is high, in_stall is high and the held result does not change.
// A clear request empties the frames and zeroes both counters.
// After reset the frames are empty, both counters are zero and the frame
// count register cfg_q is one. The user must write it with cfg_wr_en and
// cfg_wr_data while no request is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_page_replacement_dirty_defines.svh"
module fifo_page_replacement_dirty (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  fprd_pkg::cfg_t      cfg_wr_data,
	input  wire                 in_valid,
	output logic                in_stall,
	input  fprd_pkg::opcode_t   opcode,
	input  fprd_pkg::page_t     page_number,
	input  wire                 dirty,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic                hit,
	output logic                fault,
	output logic                write_back,
	output logic                evicted_valid,
	output fprd_pkg::page_t     evicted_page,
	output fprd_pkg::cnt_t      fault_count,
	output fprd_pkg::cnt_t      write_back_count
);
	import fprd_pkg::*;

	cfg_t  cfg_q;
	occ_t  occ_q;
	cnt_t  fault_total_q;
	cnt_t  wb_total_q;
	logic  out_valid_q;
	logic  hit_q;
	logic  fault_q;
	logic  wb_q;
	logic  ev_valid_q;
	page_t ev_page_q;

	logic                  in_acc;
	logic                  do_access;
	logic                  do_clear;
	logic                  any_hit;
	logic                  miss;
	logic                  full;
	logic                  evict;
	occ_t                  cap;
	occ_t                  ins_idx;
	logic [MAX_FRAMES-1:0] match_vec;
	logic [MAX_FRAMES-1:0] load_vec;
	page_t                 cell_page  [MAX_FRAMES];
	logic                  cell_dirty [MAX_FRAMES];

	assign in_stall  = out_valid_q && out_stall;
	assign in_acc    = in_valid && !in_stall;
	assign do_clear  = in_acc && (opcode == OP_CLEAR);
	assign do_access = in_acc && (opcode == OP_ACCESS);
	assign any_hit   = |match_vec;
	assign miss      = do_access && !any_hit;

	always_comb begin
		if (cfg_q == '0) begin
			cap = occ_t'(1);
		end else if (32'(cfg_q) > MAX_FRAMES) begin
			cap = occ_t'(MAX_FRAMES);
		end else begin
			cap = occ_t'(cfg_q);
		end
	end

	assign full    = (occ_q >= cap) && (occ_q != '0);
	assign evict   = miss && full;
	assign ins_idx = evict ? (occ_q - occ_t'(1)) : occ_q;

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		cell_ctrl_t ctrl;
		page_t      nxt_page;
		logic       nxt_dirty;

		assign ctrl.active  = occ_t'(i) < occ_q;
		assign ctrl.shift   = evict;
		assign ctrl.load    = miss && (ins_idx == occ_t'(i));
		assign ctrl.mark_en = do_access && dirty;
		assign load_vec[i]  = ctrl.load;

		if (i < MAX_FRAMES - 1) begin : g_link
			assign nxt_page  = cell_page[i+1];
			assign nxt_dirty = cell_dirty[i+1];
		end else begin : g_tail
			assign nxt_page  = '0;
			assign nxt_dirty = 1'b0;
		end

		fprd_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.key_page   (page_number),
			.key_dirty  (dirty),
			.next_page  (nxt_page),
			.next_dirty (nxt_dirty),
			.page       (cell_page[i]),
			.dirty      (cell_dirty[i]),
			.match      (match_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cfg_t'(1);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q         <= '0;
			fault_total_q <= '0;
			wb_total_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (do_clear) begin
				occ_q         <= '0;
				fault_total_q <= '0;
				wb_total_q    <= '0;
			end else if (miss) begin
				if (!full) begin
					occ_q <= occ_q + occ_t'(1);
				end
				if (fault_total_q != '1) begin
					fault_total_q <= fault_total_q + cnt_t'(1);
				end
				if (evict && cell_dirty[0] && (wb_total_q != '1)) begin
					wb_total_q <= wb_total_q + cnt_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hit_q      <= do_access && any_hit;
			fault_q    <= miss;
			wb_q       <= evict && cell_dirty[0];
			ev_valid_q <= evict;
			ev_page_q  <= evict ? cell_page[0] : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign fault            = fault_q;
	assign write_back       = wb_q;
	assign evicted_valid    = ev_valid_q;
	assign evicted_page     = ev_page_q;
	assign fault_count      = fault_total_q;
	assign write_back_count = wb_total_q;

	`FPRD_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= occ_t'(MAX_FRAMES))
	`FPRD_ASSERT_IMP(a_one_load, clk, arst_n, 1'b1, $onehot0(load_vec))
	`FPRD_ASSERT_NXT(a_clear_empties, clk, arst_n, do_clear, occ_q == '0)
	`FPRD_ASSERT_IMP(a_evict_is_fault, clk, arst_n, out_valid_q && ev_valid_q,
		fault_q && !hit_q)
	`FPRD_ASSERT_IMP(a_wb_needs_evict, clk, arst_n, out_valid_q && wb_q, ev_valid_q)

endmodule
`default_nettype wire
